// File: sv/bktx_pkg.sv
// ----------------------------------------------------------------------------
// bktx_pkg : shared types and constants for the trie k-th largest XOR block
// Key and store sizing, word formats, status codes and the sequencer states.
// ----------------------------------------------------------------------------
package bktx_pkg;

    localparam int KEY_BITS   = 32;
    localparam int MAX_KEYS   = 1024;

    // one root plus at most KEY_BITS new nodes per key
    localparam int NODE_COUNT = MAX_KEYS * KEY_BITS + 1;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(MAX_KEYS + 1);
    localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    localparam int VALUE_W    = 32;
    localparam int RANK_W     = 11;
    localparam int STATUS_W   = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANK = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] value;
        logic [RANK_W-1:0]  rank;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0]  xor_result;
        logic [STATUS_W-1:0] status;
    } t_out;

    // one node word: both child links and the key counts beneath each child
    typedef struct packed {
        logic [NODE_AW-1:0] child_one;
        logic [NODE_AW-1:0] child_zero;
        logic [CNT_W-1:0]   count_one;
        logic [CNT_W-1:0]   count_zero;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    // what one trie level decides
    typedef struct packed {
        logic [NODE_AW-1:0] next_node;
        t_node              node_wr;
        logic               alloc;
        logic               take;
        logic               next_fresh;
        logic [CNT_W-1:0]   left;
    } t_step;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

endpackage

// File: sv/bktx_ram.sv
// ----------------------------------------------------------------------------
// bktx_ram : generic simple dual-port RAM
// One write port, one read port, registered read data, no reset of contents.
// ----------------------------------------------------------------------------
module bktx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bktx_step.sv
// ----------------------------------------------------------------------------
// bktx_step : one trie level, shared by insert and query
// Picks the child, allocates on insert, compares and subtracts the rank.
// ----------------------------------------------------------------------------
module bktx_step (
    input  bktx_pkg::t_node                   i_node,
    input  logic                              i_fresh,
    input  logic                              i_query,
    input  logic                              i_kbit,
    input  logic [bktx_pkg::CNT_W-1:0]        i_left,
    input  logic [bktx_pkg::NODE_AW-1:0]      i_nodes_used,
    output bktx_pkg::t_step                   o_step
);

    bktx_pkg::t_node                  node;
    logic [bktx_pkg::NODE_AW-1:0]     near_link;
    logic [bktx_pkg::NODE_AW-1:0]     far_link;
    logic [bktx_pkg::NODE_AW-1:0]     new_node;
    logic [bktx_pkg::CNT_W-1:0]       far_cnt;
    logic                             absent;
    logic                             take;

    // a freshly allocated node has never been written: it reads as empty
    assign node      = i_fresh ? '0 : i_node;
    assign near_link = i_kbit ? node.child_one : node.child_zero;
    assign far_link  = i_kbit ? node.child_zero : node.child_one;
    assign far_cnt   = i_kbit ? node.count_zero : node.count_one;
    assign absent    = (near_link == '0);
    assign new_node  = bktx_pkg::NODE_AW'(i_nodes_used + 1'b1);
    assign take      = (far_cnt >= i_left);

    always_comb begin
        o_step            = '0;
        o_step.node_wr    = node;
        if (i_query) begin
            o_step.take      = take;
            o_step.next_node = take ? far_link : near_link;
            o_step.left      = take ? i_left : bktx_pkg::CNT_W'(i_left - far_cnt);
        end else begin
            o_step.alloc      = absent;
            o_step.next_fresh = absent;
            o_step.next_node  = absent ? new_node : near_link;
            o_step.left       = i_left;
            if (i_kbit) begin
                o_step.node_wr.child_one = o_step.next_node;
                o_step.node_wr.count_one = bktx_pkg::CNT_W'(node.count_one + 1'b1);
            end else begin
                o_step.node_wr.child_zero = o_step.next_node;
                o_step.node_wr.count_zero = bktx_pkg::CNT_W'(node.count_zero + 1'b1);
            end
        end
    end

endmodule

// File: sv/binary_trie_kth_max_xor.sv
// Flow: an insert or a query that walks the trie reads one node per level from the top
//   key bit down, then registers its result word; a rejected word (bad rank, full
//   store) skips the walk and goes straight to the result word register.
// Input: no new word is taken while a walk is under way or while a result word waits
//   to be loaded, one node-memory read per level; a result word held by the receiver stalls input.
// Reset: synchronous, active low; the trie reads as empty straight away, no clearing pass.
// ----------------------------------------------------------------------------
// binary_trie_kth_max_xor : binary trie with k-th largest XOR query
// Stores keys in a trie held in one node RAM and walks it one level per cycle.
// ----------------------------------------------------------------------------
module binary_trie_kth_max_xor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bktx_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bktx_pkg::t_out  o_out_data
);

    // Each node word holds both child links and the key count under each
    // child, so a level needs a single read. Node 0 is the root. Nodes are
    // handed out in order from a fill count, so a newly handed-out node has
    // not been written since reset; the step unit masks its word to empty. The root
    // is masked the same way until the first node exists.

    bktx_pkg::t_state                 r_state, n_state;
    logic                             r_op;
    logic [bktx_pkg::KEY_BITS-1:0]    r_key;
    logic [bktx_pkg::KEY_BITS-1:0]    r_acc;
    logic [bktx_pkg::CNT_W-1:0]       r_left;
    logic [bktx_pkg::LVL_W-1:0]       r_pos;
    logic [bktx_pkg::NODE_AW-1:0]     r_cur;
    logic                             r_fresh;
    logic [bktx_pkg::NODE_AW-1:0]     r_nodes_used;
    logic [bktx_pkg::CNT_W-1:0]       r_keys;
    logic [bktx_pkg::STATUS_W-1:0]    r_status;
    logic                             r_out_valid;
    bktx_pkg::t_out                   r_out;

    logic                             accept;
    logic                             bad_rank;
    logic                             full;
    logic                             load_out;
    logic                             last_lvl;
    logic [bktx_pkg::NODE_AW-1:0]     rd_addr;
    logic                             wr_en;
    bktx_pkg::t_node                  rd_node;
    bktx_pkg::t_step                  step;

    assign accept   = i_in_valid && o_in_ready;
    assign bad_rank = (i_in_data.rank == '0)
                   || (32'(i_in_data.rank) > 32'(r_keys));
    assign full     = (32'(r_keys) == 32'(bktx_pkg::MAX_KEYS));
    assign last_lvl = (r_pos == '0);
    assign load_out = (r_state == bktx_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    // ---- node memory: read root while idle, the chosen child while walking
    assign rd_addr = (r_state == bktx_pkg::S_WALK) ? step.next_node : '0;
    assign wr_en   = (r_state == bktx_pkg::S_WALK) && (r_op == bktx_pkg::OP_INSERT);

    bktx_ram #(
        .WIDTH (bktx_pkg::NODE_W),
        .DEPTH (bktx_pkg::NODE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_cur),
        .i_wdata (step.node_wr),
        .i_raddr (rd_addr),
        .o_rdata (rd_node)
    );

    // ---- shared level unit
    bktx_step u_step (
        .i_node       (rd_node),
        .i_fresh      (r_fresh),
        .i_query      (r_op == bktx_pkg::OP_QUERY),
        .i_kbit       (r_key[r_pos]),
        .i_left       (r_left),
        .i_nodes_used (r_nodes_used),
        .o_step       (step)
    );

    // ---- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            bktx_pkg::S_IDLE: begin
                if (accept) begin
                    if ((i_in_data.operation == bktx_pkg::OP_QUERY) ? bad_rank : full) begin
                        n_state = bktx_pkg::S_DONE;
                    end else begin
                        n_state = bktx_pkg::S_WALK;
                    end
                end
            end
            bktx_pkg::S_WALK: begin
                if (last_lvl) begin
                    n_state = bktx_pkg::S_DONE;
                end
            end
            bktx_pkg::S_DONE: begin
                if (load_out) begin
                    n_state = bktx_pkg::S_IDLE;
                end
            end
            default: n_state = bktx_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bktx_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---- trie bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes_used <= '0;
            r_keys       <= '0;
        end else if (r_state == bktx_pkg::S_WALK) begin
            if (step.alloc) begin
                r_nodes_used <= step.next_node;
            end
            if (last_lvl && (r_op == bktx_pkg::OP_INSERT)) begin
                r_keys <= bktx_pkg::CNT_W'(r_keys + 1'b1);
            end
        end
    end

    // ---- walk registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_in_data.operation;
            r_key    <= bktx_pkg::KEY_BITS'(i_in_data.value);
            r_left   <= bktx_pkg::CNT_W'(i_in_data.rank);
            r_acc    <= '0;
            r_pos    <= bktx_pkg::LVL_W'(bktx_pkg::KEY_BITS - 1);
            r_cur    <= '0;
            r_fresh  <= (r_nodes_used == '0);
            if (i_in_data.operation == bktx_pkg::OP_QUERY) begin
                r_status <= bad_rank ? bktx_pkg::ST_RANK : bktx_pkg::ST_OK;
            end else begin
                r_status <= full ? bktx_pkg::ST_FULL : bktx_pkg::ST_OK;
            end
        end else if (r_state == bktx_pkg::S_WALK) begin
            r_acc[r_pos] <= step.take;
            r_left       <= step.left;
            r_cur        <= step.next_node;
            r_fresh      <= step.next_fresh;
            r_pos        <= bktx_pkg::LVL_W'(r_pos - 1'b1);
        end
    end

    // ---- output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.xor_result <= bktx_pkg::VALUE_W'(r_acc);
            r_out.status     <= r_status;
        end
    end

    assign o_in_ready  = (r_state == bktx_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sv/bktx_chk.sv
// ----------------------------------------------------------------------------
// bktx_chk : port checker for the trie k-th largest XOR block
// Watches the handshakes and result words on the top level's ports.
// ----------------------------------------------------------------------------
module bktx_chk (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            o_in_ready,
    input  bktx_pkg::t_in   i_in_data,
    input  logic            o_out_valid,
    input  logic            i_out_ready,
    input  bktx_pkg::t_out  o_out_data
);

    // a waiting result word must hold
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result word dropped or changed while stalled");

    // a rejected word carries a zero result
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != bktx_pkg::ST_OK))
            |-> (o_out_data.xor_result == '0))
        else $error("error status with non-zero result");

    // one word at a time: busy right after an accepted word
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready straight after an accepted word");

    // status codes stay within the defined set
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.status == bktx_pkg::ST_OK)
                      || (o_out_data.status == bktx_pkg::ST_RANK)
                      || (o_out_data.status == bktx_pkg::ST_FULL)))
        else $error("undefined status code");

endmodule

bind binary_trie_kth_max_xor bktx_chk u_bktx_chk (.*);

// File: tb/sv/trie_xor_checker.sv
// ----------------------------------------------------------------------------
// trie_xor_checker : watches the trie block's channels and checks every result
// Keeps its own trie of the keys accepted so far, works out the answer to each
// accepted word and compares it field by field with the block's result words.
// ----------------------------------------------------------------------------
module trie_xor_checker
    import bktx_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_failures,
    output int   o_waiting
);

    // shadow trie: node 0 is the root, a zero link means no child
    int unsigned link_zero  [NODE_COUNT];
    int unsigned link_one   [NODE_COUNT];
    int unsigned keys_below [NODE_COUNT];
    int unsigned nodes_taken = 0;
    int unsigned keys_total  = 0;

    t_out answers_due [$];
    t_out want;

    initial begin
        o_failures = 0;
        o_waiting  = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] mismatch, %s: got %h, expected %h", $time, what, got, exp_val);
        o_failures++;
    endtask

    // applies one word to the shadow trie and returns the answer it should give
    function automatic t_out trie_step(input t_in w);
        t_out        r;
        int          lvl;
        int unsigned node;
        int unsigned nxt;
        int unsigned far;
        int unsigned n;
        int unsigned left;
        logic        b;
        r    = '0;
        node = 0;
        if (w.operation == OP_INSERT) begin
            if (keys_total >= MAX_KEYS) begin
                r.status = ST_FULL;
            end else begin
                for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                    b   = w.value[lvl];
                    nxt = b ? link_one[node] : link_zero[node];
                    if (nxt == 0) begin
                        nodes_taken++;
                        nxt = nodes_taken;
                        if (b)
                            link_one[node] = nxt;
                        else
                            link_zero[node] = nxt;
                    end
                    node = nxt;
                    keys_below[node]++;
                end
                keys_total++;
                r.status = ST_OK;
            end
        end else if (w.rank == '0 || 32'(w.rank) > keys_total) begin
            r.status = ST_RANK;
        end else begin
            left = 32'(w.rank);
            for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
                b   = w.value[lvl];
                far = b ? link_zero[node] : link_one[node];
                n   = (far == 0) ? 0 : keys_below[far];
                if (n >= left) begin
                    node              = far;
                    r.xor_result[lvl] = 1'b1;
                end else begin
                    left -= n;
                    node  = b ? link_one[node] : link_zero[node];
                end
            end
            r.status = ST_OK;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answers_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result word with none outstanding",
                                    i_out_data.xor_result, '0);
                end else begin
                    want = answers_due.pop_front();
                    if (i_out_data.xor_result !== want.xor_result)
                        report_mismatch("xor_result", i_out_data.xor_result,
                                        want.xor_result);
                    if (i_out_data.status !== want.status)
                        report_mismatch("status", 32'(i_out_data.status),
                                        32'(want.status));
                end
            end
            if (i_in_valid && i_in_ready)
                answers_due.push_back(trie_step(i_in_data));
        end
        o_waiting <= answers_due.size();
    end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench : stimulus and verdict for the trie k-th largest XOR block
// A directed opening, then a long random mix of inserts and queries that grows
// the store to several hundred keys; both channels idle at random, with one long stall.
// ----------------------------------------------------------------------------
module testbench;
    import bktx_pkg::*;

    localparam int RANDOM_WORDS = 933;
    localparam int INSERT_PCT   = 70;             // share of inserts in the random mix
    localparam int HOLD_CYCLES  = 600;            // one long back-pressure stall
    localparam int DRAIN_CYCLES = 40;             // margin for any stray result word after the drain
    localparam int CYCLE_LIMIT  = 600000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    t_out out_data;
    int   failures;
    int   waiting;

    // stimulus-side view of the store, so ranks can be aimed at the keys held
    int unsigned        keys_held    = 0;
    logic [VALUE_W-1:0] key_log [$];
    logic [VALUE_W-1:0] prefix_pool [8];

    // idling control: steady switches off random gaps on both sides,
    // squeeze asks for the single long hold-off on the result channel
    logic        steady    = 1'b0;
    logic        squeeze   = 1'b0;
    logic        squeezed  = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    binary_trie_kth_max_xor u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    trie_xor_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_failures  (failures),
        .o_waiting   (waiting)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // long hold-off, counted down in its own process once squeeze is raised
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (squeeze && !squeezed) begin
            hold_left <= HOLD_CYCLES;
            squeezed  <= 1'b1;
        end
    end

    // result side: ready drops in about a quarter of cycles, never while steady,
    // and stays low throughout the hold-off so the block backs up into its input
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left != 0)
            out_ready <= 1'b0;
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) >= 26);
    end

    // Keys are drawn so the trie gets both deep shared prefixes and wide fan-out:
    // fully random words, a few fixed prefixes with random low bytes, repeats of
    // stored keys (duplicates must count twice) and the all-zero / all-one /
    // single-bit extremes.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned kind;
        int unsigned k;
        kind = $urandom_range(0, 9);
        k    = $urandom_range(0, VALUE_W - 1);
        if (kind < 4)
            return $urandom;
        if (kind < 7)
            return prefix_pool[3'($urandom_range(0, 7))] ^ $urandom_range(0, 255);
        if (kind < 9 && key_log.size() != 0)
            return key_log[$urandom_range(0, key_log.size() - 1)];
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1 << k;
            default: return ~(32'd1 << k);
        endcase
    endfunction

    // Query ranks mostly land inside 1..keys held; the rest test rank zero,
    // one past the top, and anything the 11-bit field can carry.
    // On an insert the rank is junk, which the block must ignore.
    function automatic logic [RANK_W-1:0] pick_rank(input logic op);
        int unsigned kind;
        kind = $urandom_range(0, 19);
        if (op == OP_INSERT || keys_held == 0)
            return RANK_W'($urandom_range(0, 2047));
        if (kind < 12)
            return RANK_W'($urandom_range(1, keys_held));
        if (kind < 14)
            return RANK_W'(1);
        if (kind < 16)
            return RANK_W'(keys_held);
        if (kind == 16)
            return '0;
        if (kind == 17)
            return RANK_W'(keys_held + 1);
        return RANK_W'($urandom_range(0, 2047));
    endfunction

    // Offers one word, called at a rising edge and returning at the edge that
    // accepts it. An optional random gap first drops valid; otherwise valid
    // simply stays high into the next word. Ready only moves at a rising edge,
    // so looking at it on the falling edge tells whether the next edge takes the word.
    task automatic offer(input logic op, input logic [VALUE_W-1:0] val,
                         input logic [RANK_W-1:0] rnk);
        t_in         w;
        int unsigned gap;
        w.operation = op;
        w.value     = val;
        w.rank      = rnk;
        gap         = 0;
        if (!steady && $urandom_range(0, 99) < 26)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        if (op == OP_INSERT) begin
            if (keys_held < MAX_KEYS) begin
                keys_held++;
                key_log.push_back(val);
            end
        end
    endtask

    initial begin
        int unsigned n_rand;
        logic        op;
        n_rand = 0;
        for (int i = 0; i < 8; i++)
            prefix_pool[i] = $urandom;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty trie: every rank is out of range
        offer(OP_QUERY,  32'h0000_0000, 11'd1);
        offer(OP_QUERY,  32'h0000_0000, 11'd0);
        // a small store with a duplicate and both extremes
        offer(OP_INSERT, 32'h0000_0000, 11'd0);
        offer(OP_INSERT, 32'hFFFF_FFFF, 11'd2047);
        offer(OP_INSERT, 32'h0000_0000, 11'd1024);
        offer(OP_INSERT, 32'h8000_0000, 11'd5);
        offer(OP_INSERT, 32'h5555_5555, 11'd0);
        offer(OP_INSERT, 32'hAAAA_AAAA, 11'd3);
        // top and bottom ranks, then just past the top, zero and the field maximum
        offer(OP_QUERY,  32'h0000_0000, 11'd1);
        offer(OP_QUERY,  32'h0000_0000, 11'd6);
        offer(OP_QUERY,  32'h0000_0000, 11'd7);
        offer(OP_QUERY,  32'h0000_0000, 11'd0);
        offer(OP_QUERY,  32'h0000_0000, 11'd2047);
        // the duplicate zero key gives the same answer at two ranks
        offer(OP_QUERY,  32'hFFFF_FFFF, 11'd1);
        offer(OP_QUERY,  32'hFFFF_FFFF, 11'd2);
        offer(OP_QUERY,  32'h5555_5555, 11'd3);
        offer(OP_QUERY,  32'h1234_5678, 11'd4);

        // Random mix, insert-heavy so the store grows to several hundred keys
        // and query ranks spread over a wide range.
        while (n_rand < RANDOM_WORDS) begin
            steady <= (n_rand >= 150 && n_rand < 350);
            if (n_rand == 500)
                squeeze <= 1'b1;
            op = ($urandom_range(0, 99) < INSERT_PCT) ? OP_INSERT : OP_QUERY;
            offer(op, pick_value(), pick_rank(op));
            n_rand++;
        end
        in_valid <= 1'b0;

        // let the last walks finish, then a margin for any stray word
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
